// File: rtl/four_way_position_hash_table_core_defines.svh
// ----------------------------------------------------------------------------
// Four-way position hash table assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef FOUR_WAY_POSITION_HASH_TABLE_CORE_DEFINES_SVH
`define FOUR_WAY_POSITION_HASH_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define FWPH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FWPH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fwph_pkg.sv
// ----------------------------------------------------------------------------
// fwph_pkg
// Types and constants of the four-way position hash table.
// ----------------------------------------------------------------------------
package fwph_pkg;

  localparam int unsigned WAYS        = 4;
  localparam int unsigned WAY_W       = 2;
  localparam int unsigned IN_TDATA_W  = 152;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [14:0] MATE_THR_RESET = 15'd30000;

  typedef enum logic [1:0] {
    ACT_PROBE      = 2'd0,
    ACT_PROBE_MOVE = 2'd1,
    ACT_STORE      = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    CFG_GENERATION = 1'b0,
    CFG_MATE_THR   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] move;
    logic [15:0] score;
    logic [1:0]  flags;
    logic [7:0]  depth;
    logic [7:0]  date;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [1:0]  bound_flags;
    logic [7:0]  ply;
    logic [7:0]  depth;
    logic [15:0] beta;
    logic [15:0] alpha;
    logic [15:0] score_in;
    logic [15:0] move_in;
    logic [63:0] key;
  } in_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] score_out;
    logic        score_valid;
    logic [15:0] move_out;
    logic        found;
    logic        cutoff;
  } out_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic clr_wr;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic clr_last;
  } sts_t;

endpackage

// File: rtl/fwph_ram.sv
// ----------------------------------------------------------------------------
// fwph_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fwph_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fwph_dp.sv
// ----------------------------------------------------------------------------
// fwph_dp
// Datapath: input capture, bucket RAM, hit and victim select, write-back,
// configuration registers and result register.
// ----------------------------------------------------------------------------
module fwph_dp #(
  parameter int unsigned NUM_ENTRIES = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fwph_pkg::cmd_t                     cmd_i,
  output fwph_pkg::sts_t                     sts_o,
  input  logic [fwph_pkg::IN_TDATA_W-1:0]    s_tdata_i,
  input  logic [1:0]                         s_tuser_i,
  input  logic                               cfg_we_i,
  input  logic [0:0]                         cfg_idx_i,
  input  logic [14:0]                        cfg_data_i,
  output logic [fwph_pkg::OUT_TDATA_W-1:0]   m_tdata_o
);

  localparam int unsigned ROWS  = NUM_ENTRIES / fwph_pkg::WAYS;
  localparam int unsigned ROW_W = $clog2(ROWS);

  fwph_pkg::in_t     s_in;
  fwph_pkg::in_t     in_q;
  fwph_pkg::action_e act_q;
  logic [7:0]        gen_q;
  logic [14:0]       thr_q;
  logic [ROW_W-1:0]  cnt_q, cnt_d;
  fwph_pkg::out_t    out_q, out_d;

  fwph_pkg::row_t    row, new_row;
  logic [$bits(fwph_pkg::row_t)-1:0] rd_data;
  logic [$bits(fwph_pkg::row_t)-1:0] wr_data;
  logic [ROW_W-1:0]  wr_addr;
  logic              wr_en;

  logic [fwph_pkg::WAYS-1:0]  hv;
  logic [15:0]                age [fwph_pkg::WAYS];
  logic                       hit;
  logic [fwph_pkg::WAY_W-1:0] hit_way, victim, wway;
  logic [15:0]                best;
  fwph_pkg::entry_t           e, ne;

  logic signed [16:0] st, thr17, ply17, ps, ss, sin17;
  logic signed [15:0] pscore, sscore;
  logic               is_probe, sv;

  assign s_in = fwph_pkg::in_t'(s_tdata_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_q  <= s_in;
      act_q <= fwph_pkg::action_e'(s_tuser_i);
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
      thr_q <= fwph_pkg::MATE_THR_RESET;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.exec && act_q == fwph_pkg::ACT_CLEAR) begin
        gen_q <= '0;
      end else if (cfg_we_i && cfg_idx_i == fwph_pkg::CFG_GENERATION) begin
        gen_q <= cfg_data_i[7:0];
      end
      if (cfg_we_i && cfg_idx_i == fwph_pkg::CFG_MATE_THR) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  assign cnt_d = cmd_i.clr_wr ? cnt_q + 1'b1 : cnt_q;

  fwph_ram #(
    .WIDTH ($bits(fwph_pkg::row_t)),
    .DEPTH (ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (cmd_i.accept),
    .raddr_i (s_in.key[ROW_W+1:2]),
    .rdata_o (rd_data)
  );

  assign row = fwph_pkg::row_t'(rd_data);

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = fwph_pkg::WAYS - 1; w >= 0; w--) begin
      hv[w]  = (row[w].key == in_q.key);
      age[w] = {gen_q - row[w].date, ~row[w].depth};
      if (hv[w]) begin
        hit     = 1'b1;
        hit_way = fwph_pkg::WAY_W'(w);
      end
    end
    victim = '0;
    best   = age[0];
    for (int w = 1; w < fwph_pkg::WAYS; w++) begin
      if (age[w] > best) begin
        best   = age[w];
        victim = fwph_pkg::WAY_W'(w);
      end
    end
  end

  assign e     = row[hit_way];
  assign st    = 17'(signed'(e.score));
  assign thr17 = signed'({2'b00, thr_q});
  assign ply17 = signed'({9'd0, in_q.ply});
  assign sin17 = 17'(signed'(in_q.score_in));

  always_comb begin
    if (st < -thr17) begin
      ps = st + ply17;
    end else if (st > thr17) begin
      ps = st - ply17;
    end else begin
      ps = st;
    end
    pscore = ps[15:0];

    if (sin17 < -thr17) begin
      ss = sin17 - ply17;
    end else if (sin17 > thr17) begin
      ss = sin17 + ply17;
    end else begin
      ss = sin17;
    end
    if (ss < -17'sd32768) begin
      sscore = 16'sh8000;
    end else if (ss > 17'sd32767) begin
      sscore = 16'sh7fff;
    end else begin
      sscore = ss[15:0];
    end
  end

  assign is_probe = (act_q == fwph_pkg::ACT_PROBE) || (act_q == fwph_pkg::ACT_PROBE_MOVE);
  assign sv       = (act_q == fwph_pkg::ACT_PROBE) && hit && (e.depth >= in_q.depth);
  assign wway     = hit ? hit_way : victim;

  always_comb begin
    ne.key   = in_q.key;
    ne.move  = (hit && in_q.move_in == '0) ? e.move : in_q.move_in;
    ne.score = sscore;
    ne.flags = in_q.bound_flags;
    ne.depth = in_q.depth;
    ne.date  = gen_q;
    new_row  = row;
    if (act_q == fwph_pkg::ACT_STORE) begin
      new_row[wway] = ne;
    end else begin
      new_row[hit_way].date = gen_q;
    end
  end

  always_comb begin
    out_d             = '0;
    out_d.found       = hit && (is_probe || act_q == fwph_pkg::ACT_STORE);
    out_d.move_out    = (is_probe && hit) ? e.move : '0;
    out_d.score_valid = sv;
    out_d.score_out   = sv ? pscore : '0;
    out_d.cutoff      = sv && ((e.flags[0] && pscore <= signed'(in_q.alpha)) ||
                               (e.flags[1] && pscore >= signed'(in_q.beta)));
  end

  assign wr_en   = cmd_i.clr_wr ||
                   (cmd_i.exec && ((act_q == fwph_pkg::ACT_STORE) || (is_probe && hit)));
  assign wr_addr = cmd_i.clr_wr ? cnt_q : in_q.key[ROW_W+1:2];
  assign wr_data = cmd_i.clr_wr ? '0 : new_row;

  assign sts_o.is_clear = (act_q == fwph_pkg::ACT_CLEAR);
  assign sts_o.clr_last = (cnt_q == {ROW_W{1'b1}});
  assign m_tdata_o      = out_q;

endmodule

// File: rtl/fwph_ctrl.sv
// ----------------------------------------------------------------------------
// fwph_ctrl
// Controller: clearing sweep, accept, execute and result valid.
// ----------------------------------------------------------------------------
module fwph_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  output fwph_pkg::cmd_t cmd_o,
  input  fwph_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_CLR  = 3'b001,
    ST_IDLE = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    s_tready_o   = 1'b0;
    out_valid_d  = out_valid_q && !m_tready_i;
    unique case (state_q)
      ST_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready_o   = 1'b1;
        cmd_o.accept = s_tvalid_i;
        if (s_tvalid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = sts_i.is_clear ? ST_CLR : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

endmodule

// File: rtl/four_way_position_hash_table_core.sv
// ----------------------------------------------------------------------------
// four_way_position_hash_table_core
// Four-way bucketed position hash table with probe, store and clear.
// ----------------------------------------------------------------------------
// Each probe or store reads the bucket row (all four ways) from a single RAM
// in the accept cycle and writes it back on a hit or a store in the execute
// state, which waits while the result register is full, so a new transaction
// is not taken until the previous one has executed. After reset and after a
// clear transaction the table is swept one row per cycle, during which no
// transaction is accepted; configuration writes are taken at any time, but a clear overrides a generation write.
module four_way_position_hash_table_core #(
  parameter int unsigned NUM_ENTRIES = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // key, move_in, score_in, alpha, beta, depth, ply, bound_flags, zero pad
  input  logic [fwph_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // cutoff, found, move_out, score_valid, score_out, zero pad
  output logic [fwph_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_idx_i,
  input  logic [14:0]                      cfg_data_i
);

  `include "four_way_position_hash_table_core_defines.svh"

  fwph_pkg::cmd_t cmd;
  fwph_pkg::sts_t sts;

  fwph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  fwph_dp #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .m_tdata_o  (m_axis_tdata)
  );

  `FWPH_ASSERT_IMP(a_no_accept_in_sweep, cmd.clr_wr, !s_axis_tready, "accept during clear sweep")
  `FWPH_ASSERT_NXT(a_exec_gives_result, cmd.exec, m_axis_tvalid, "result not presented")
  `FWPH_ASSERT_NXT(a_one_in_flight, cmd.accept, !s_axis_tready, "second transaction in flight")
  `FWPH_ASSERT_IMP(a_exec_not_accept, cmd.exec, !cmd.accept && !cmd.clr_wr, "command overlap")

endmodule

// File: tb/tb_four_way_position_hash_table_core.sv
// ----------------------------------------------------------------------------
// Four-way position hash table testbench
// Drives probe, store and clear transactions with random idling on both
// stream sides, predicts every result from a behavioral copy of the table
// and compares it field by field with the returned transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_four_way_position_hash_table_core;

  localparam int unsigned NUM_ENTRIES = 4096;

  typedef struct {
    fwph_pkg::action_e  act;
    fwph_pkg::in_t      data;
    logic               cfg_valid;
    fwph_pkg::cfg_idx_e cfg_idx;
    logic [14:0]        cfg_value;
  } txn_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [fwph_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [fwph_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [14:0] cfg_data_i = '0;

  four_way_position_hash_table_core #(.NUM_ENTRIES(NUM_ENTRIES)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fwph_pkg::entry_t tbl [NUM_ENTRIES];
  logic [7:0]       gen;
  logic [14:0]      mate_thr;
  txn_t             pending_q [$];
  fwph_pkg::out_t   expected_q [$];
  int               errors = 0;
  int               accepted = 0;
  int               sent = 0;
  bit               calm = 1'b0;
  logic [63:0]      keys [16];

  function automatic int sat16(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic fwph_pkg::out_t lookup_and_update(fwph_pkg::action_e act,
                                                       fwph_pkg::in_t d);
    fwph_pkg::out_t r;
    int base, hit, idx, s, thr, best, age;
    r = '0;
    base = int'(d.key[11:0]) & (NUM_ENTRIES - 4);
    thr = int'(mate_thr);
    hit = -1;
    if (act == fwph_pkg::ACT_CLEAR) begin
      foreach (tbl[i]) tbl[i] = '0;
      gen = '0;
      return r;
    end
    for (int w = 0; w < 4; w++)
      if (hit < 0 && tbl[base + w].key == d.key) hit = w;
    if (act == fwph_pkg::ACT_STORE) begin
      s = int'($signed(d.score_in));
      if (s < -thr) s -= int'(d.ply);
      else if (s > thr) s += int'(d.ply);
      s = sat16(s);
      if (hit >= 0) begin
        idx = base + hit;
        r.found = 1'b1;
        if (d.move_in == 0) d.move_in = tbl[idx].move;
      end else begin
        best = -1;
        idx = base;
        for (int w = 0; w < 4; w++) begin
          age = int'(8'(gen - tbl[base + w].date)) * 256 + 255 - int'(tbl[base + w].depth);
          if (age > best) begin
            best = age;
            idx = base + w;
          end
        end
      end
      tbl[idx] = '{key: d.key, move: d.move_in, score: 16'(s), flags: d.bound_flags,
                   depth: d.depth, date: gen};
      return r;
    end
    if (hit < 0) return r;
    idx = base + hit;
    tbl[idx].date = gen;
    r.found = 1'b1;
    r.move_out = tbl[idx].move;
    if (act == fwph_pkg::ACT_PROBE && tbl[idx].depth >= d.depth) begin
      s = int'($signed(tbl[idx].score));
      if (s < -thr) s += int'(d.ply);
      else if (s > thr) s -= int'(d.ply);
      r.score_valid = 1'b1;
      r.score_out = 16'(s);
      if ((tbl[idx].flags[0] && s <= int'($signed(d.alpha))) ||
          (tbl[idx].flags[1] && s >= int'($signed(d.beta))))
        r.cutoff = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_score();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(29000, 32767));
      1: return 16'(-int'($urandom_range(29000, 32768)));
      2: return 16'($urandom_range(0, 200) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic txn_t rand_item(fwph_pkg::action_e act);
    txn_t t;
    t.act = act;
    t.cfg_valid = 1'b0;
    t.cfg_idx = fwph_pkg::CFG_GENERATION;
    t.cfg_value = '0;
    t.data = '0;
    t.data.key = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                             : keys[$urandom_range(0, 15)];
    t.data.move_in = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
    t.data.score_in = rand_score();
    t.data.alpha = rand_score();
    t.data.beta = rand_score();
    t.data.depth = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 12)) : 8'($urandom);
    t.data.ply = 8'($urandom);
    t.data.bound_flags = 2'($urandom);
    return t;
  endfunction

  function automatic txn_t cfg_item(fwph_pkg::cfg_idx_e idx, logic [14:0] v);
    txn_t t;
    t = rand_item(fwph_pkg::ACT_PROBE);
    t.cfg_valid = 1'b1;
    t.cfg_idx = idx;
    t.cfg_value = v;
    return t;
  endfunction

  // driver: a config entry is applied only once no transaction is in flight and every result has been returned
  always @(posedge clk_i) begin
    logic cfg_we_n;
    cfg_we_n = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        accepted <= accepted + 1;
        expected_q.push_back(lookup_and_update(fwph_pkg::action_e'(s_axis_tuser),
                                               fwph_pkg::in_t'(s_axis_tdata)));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 && pending_q[0].cfg_valid) begin
          s_axis_tvalid <= 1'b0;
          if (!(s_axis_tvalid && s_axis_tready) && expected_q.size() == 0
              && accepted == sent) begin
            cfg_we_n = 1'b1;
            cfg_idx_i <= pending_q[0].cfg_idx;
            cfg_data_i <= pending_q[0].cfg_value;
            if (pending_q[0].cfg_idx == fwph_pkg::CFG_GENERATION)
              gen = pending_q[0].cfg_value[7:0];
            else mate_thr = pending_q[0].cfg_value;
            void'(pending_q.pop_front());
          end
        end else if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 25)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= pending_q[0].act;
          s_axis_tdata <= pending_q[0].data;
          sent <= sent + 1;
          void'(pending_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
    cfg_we_i <= cfg_we_n;
  end

  // monitor
  always @(posedge clk_i) begin
    fwph_pkg::out_t got, want;
    if (rst_ni) begin
      m_axis_tready <= calm || $urandom_range(0, 99) >= 25;
      if (m_axis_tvalid && m_axis_tready) begin
        got = fwph_pkg::out_t'(m_axis_tdata);
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = expected_q.pop_front();
          if (got.cutoff !== want.cutoff || got.found !== want.found ||
              got.move_out !== want.move_out || got.score_valid !== want.score_valid ||
              got.score_out !== want.score_out) begin
            errors++;
            $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
          end
        end
      end
    end
  end

  initial begin
    txn_t t;
    fwph_pkg::action_e acts [4];
    acts = '{fwph_pkg::ACT_PROBE, fwph_pkg::ACT_PROBE_MOVE, fwph_pkg::ACT_STORE,
             fwph_pkg::ACT_CLEAR};
    gen = '0;
    mate_thr = fwph_pkg::MATE_THR_RESET;
    foreach (tbl[i]) tbl[i] = '0;
    foreach (keys[i]) keys[i] = {$urandom, 20'($urandom), 12'(i & 4'hc)};
    keys[0] = '0;
    keys[1] = '1;
    // directed: zero key hits cleared entries, extremes, saturation
    t = rand_item(fwph_pkg::ACT_PROBE); t.data.key = '0; t.data.depth = 0;
    pending_q.push_back(t);
    t = rand_item(fwph_pkg::ACT_PROBE_MOVE); t.data.key = '0; pending_q.push_back(t);
    t = rand_item(fwph_pkg::ACT_PROBE); t.data.key = '1; pending_q.push_back(t);
    t = rand_item(fwph_pkg::ACT_STORE); t.data.key = '1; t.data.score_in = 16'h7fff;
    t.data.ply = 8'hff; t.data.depth = 8'hff; t.data.bound_flags = 2'b11;
    t.data.move_in = 16'hffff; pending_q.push_back(t);
    t = rand_item(fwph_pkg::ACT_PROBE); t.data.key = '1; t.data.depth = 8'hff;
    t.data.ply = 8'hff;
    t.data.alpha = 16'h8000; t.data.beta = 16'h7fff; pending_q.push_back(t);
    t = rand_item(fwph_pkg::ACT_STORE); t.data.key = '1; t.data.score_in = 16'h8000;
    t.data.ply = 8'hff; t.data.move_in = 0; t.data.depth = 0; pending_q.push_back(t);
    t = rand_item(fwph_pkg::ACT_PROBE); t.data.key = '1; t.data.depth = 0;
    pending_q.push_back(t);
    t = rand_item(fwph_pkg::ACT_PROBE); t.data.key = '1; t.data.depth = 1;
    pending_q.push_back(t);
    for (int i = 0; i < 6; i++) begin
      t = rand_item(fwph_pkg::ACT_STORE); t.data.key = keys[2] ^ (64'(i) << 40);
      t.data.depth = 8'(i * 40); pending_q.push_back(t);
    end
    pending_q.push_back(cfg_item(fwph_pkg::CFG_GENERATION, 15'd255));
    pending_q.push_back(cfg_item(fwph_pkg::CFG_MATE_THR, 15'd0));
    for (int i = 0; i < 4; i++) pending_q.push_back(rand_item(acts[i]));
    pending_q.push_back(cfg_item(fwph_pkg::CFG_MATE_THR, 15'h7fff));
    t = rand_item(fwph_pkg::ACT_STORE); t.data.score_in = 16'h7fff; pending_q.push_back(t);
    for (int ph = 0; ph < 8; ph++) begin
      pending_q.push_back(cfg_item(fwph_pkg::CFG_GENERATION,
                                   15'($urandom_range(0, 255))));
      pending_q.push_back(cfg_item(fwph_pkg::CFG_MATE_THR, (ph == 3) ? 15'd0 :
                                   15'($urandom_range(29000, 32767))));
      for (int i = 0; i < 250; i++) begin
        t = rand_item($urandom_range(0, 1) ? fwph_pkg::ACT_STORE
                      : ($urandom_range(0, 3) == 0 ? fwph_pkg::ACT_PROBE_MOVE
                                                   : fwph_pkg::ACT_PROBE));
        if ($urandom_range(0, 499) == 0) t.act = fwph_pkg::ACT_CLEAR;
        pending_q.push_back(t);
      end
    end
    pending_q.push_back(cfg_item(fwph_pkg::CFG_MATE_THR, fwph_pkg::MATE_THR_RESET));
    for (int i = 0; i < 16; i++) pending_q.push_back(rand_item(fwph_pkg::ACT_PROBE));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      forever begin
        repeat (3000) @(posedge clk_i);
        calm = 1'b1;
        repeat (400) @(posedge clk_i);
        calm = 1'b0;
      end
    join_none
    wait (pending_q.size() == 0 && !s_axis_tvalid && accepted == sent
          && expected_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/fwph_pkg.sv
rtl/fwph_ram.sv
rtl/fwph_dp.sv
rtl/fwph_ctrl.sv
rtl/four_way_position_hash_table_core.sv
tb/tb_four_way_position_hash_table_core.sv
